FILE: hdl/sorted_priority_table_unit_defines.svh
// Assertion macros for the sorted priority table unit checker.
`ifndef SORTED_PRIORITY_TABLE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_TABLE_UNIT_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define SPTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SPTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sptu_pkg.sv
// Shared types and codes for the sorted priority table unit.
`default_nettype none

package sptu_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pages;
    logic [7:0]  prio;
    logic [15:0] name;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_priority_table_unit.sv
// Sorted priority table of job entries with insert, remove, lookup and update.
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+---------------------
//  request | kind doc_id page_count prio_level name_tag     | req_valid / req_stall
//  response| status hit_pages hit_prio hit_name entry_count | rsp_valid / rsp_stall
//
// One word at a time; the slot memory has one read port and delivers one entry a cycle.
// Lookup and update scan for the first id match; update rewrites that entry in place.
// Remove shifts later entries down; insert goes before the first entry of higher prio.
// Insert to a full table answers full; others to an empty table answer not found.
// Synchronous reset empties the table at once; slot contents are not cleared.
// A stalled response is held; the next request word is taken while it waits.
`default_nettype none

module sorted_priority_table_unit import sptu_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] doc_id,
  input  logic [15:0] page_count,
  input  logic [7:0]  prio_level,
  input  logic [15:0] name_tag,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [15:0] hit_pages,
  output logic [7:0]  hit_prio,
  output logic [15:0] hit_name,
  output logic [4:0]  entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PRIME,
    S_SHIFT,
    S_PLACE,
    S_RSHIFT,
    S_DONE
  } state_t;

  state_t        state;
  kind_t         op_kind;
  entry_t        op_entry;
  logic [CW-1:0] fill;
  logic [CW-1:0] ridx;
  logic [CW-1:0] pos;
  status_t       res_status;
  entry_t        res_hit;

  entry_t        slots [DEPTH];
  entry_t        rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;

  entry_t        req_entry;
  logic [CW-1:0] ridx_inc;
  logic [CW-1:0] ridx_dec;
  logic [CW:0]   ridx_inc2;
  logic          scan_hit;
  logic          scan_last;
  logic          out_room;

  assign req_entry = '{id: doc_id, pages: page_count, prio: prio_level, name: name_tag};
  assign ridx_inc  = ridx + 1'b1;
  assign ridx_dec  = ridx - 1'b1;
  assign ridx_inc2 = {1'b0, ridx} + (CW + 1)'(2);
  assign scan_hit  = (op_kind == KIND_INSERT) ? (rd_data.prio > op_entry.prio)
                                              : (rd_data.id == op_entry.id);
  assign scan_last = (ridx_inc == fill);
  assign out_room  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_waddr] <= mem_wdata;
    end
    rd_data <= slots[mem_raddr];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ridx[AW-1:0];
    mem_wdata = rd_data;
    mem_raddr = '0;
    unique case (state)
      S_SCAN: begin
        mem_raddr = ridx_inc[AW-1:0];
        if (scan_hit && op_kind == KIND_UPDATE) begin
          mem_we    = 1'b1;
          mem_wdata = op_entry;
        end
      end
      S_PRIME: begin
        mem_raddr = ridx[AW-1:0];
      end
      S_SHIFT: begin
        mem_raddr = ridx_dec[AW-1:0];
        mem_we    = 1'b1;
        mem_waddr = ridx_inc[AW-1:0];
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = op_entry;
      end
      S_RSHIFT: begin
        mem_raddr = ridx_inc2[AW-1:0];
        mem_we    = !scan_last;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_kind    <= kind_t'(kind);
            op_entry   <= req_entry;
            res_hit    <= '0;
            ridx       <= '0;
            pos        <= fill;
            if (kind_t'(kind) == KIND_INSERT) begin
              if (fill == CW'(DEPTH)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (fill == '0) begin
                res_status <= ST_OK;
                state      <= S_PLACE;
              end else begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
            end else if (fill == '0) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            pos <= ridx;
            unique case (op_kind)
              KIND_INSERT: begin
                ridx  <= fill - 1'b1;
                state <= S_PRIME;
              end
              KIND_REMOVE: begin
                res_hit <= rd_data;
                state   <= S_RSHIFT;
              end
              KIND_LOOKUP: begin
                res_hit <= rd_data;
                state   <= S_DONE;
              end
              KIND_UPDATE: begin
                res_hit <= op_entry;
                state   <= S_DONE;
              end
            endcase
          end else if (scan_last) begin
            if (op_kind == KIND_INSERT) begin
              pos   <= fill;
              state <= S_PLACE;
            end else begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end else begin
            ridx <= ridx_inc;
          end
        end
        S_PRIME: begin
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (ridx == pos) begin
            state <= S_PLACE;
          end else begin
            ridx <= ridx_dec;
          end
        end
        S_PLACE: begin
          fill  <= fill + 1'b1;
          state <= S_DONE;
        end
        S_RSHIFT: begin
          if (scan_last) begin
            fill  <= fill - 1'b1;
            state <= S_DONE;
          end else begin
            ridx <= ridx_inc;
          end
        end
        S_DONE: begin
          if (out_room) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            hit_pages   <= res_hit.pages;
            hit_prio    <= res_hit.prio;
            hit_name    <= res_hit.name;
            entry_count <= 5'(fill);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sptu_checker.sv
// Port-level checker for the sorted priority table unit, bound to the top level.
`default_nettype none
`include "sorted_priority_table_unit_defines.svh"

module sptu_checker import sptu_pkg::*; #(
  parameter int DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic        rsp_valid,
  input wire logic        rsp_stall,
  input wire logic [1:0]  status,
  input wire logic [15:0] hit_pages,
  input wire logic [7:0]  hit_prio,
  input wire logic [15:0] hit_name,
  input wire logic [4:0]  entry_count
);

  `SPTU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")
  `SPTU_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "ready after take")
  `SPTU_ASSERT_NOW(a_miss_zero, rsp_valid && status != ST_OK, hit_pages == '0 && hit_prio == '0 && hit_name == '0, "hit fields set on miss")
  `SPTU_ASSERT_NOW(a_full_count, rsp_valid && status == ST_FULL, entry_count == 5'(DEPTH), "full without full count")

endmodule

bind sorted_priority_table_unit sptu_checker #(.DEPTH(DEPTH)) u_sptu_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .status      (status),
  .hit_pages   (hit_pages),
  .hit_prio    (hit_prio),
  .hit_name    (hit_name),
  .entry_count (entry_count)
);

`default_nettype wire

FILE: verif/tb_sorted_priority_table_unit.sv
// Self-checking testbench for the sorted priority table unit: random job traffic against a table model.
`timescale 1ns / 100ps
`default_nettype none

module tb_sorted_priority_table_unit import sptu_pkg::*;;

  localparam int TABLE_DEPTH     = 16;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int LONG_HOLD_LEN   = 400;
  localparam int LONG_HOLD_AFTER = 120;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    kind_t       op;
    logic [15:0] id;
    logic [15:0] pages;
    logic [7:0]  prio;
    logic [15:0] name;
  } job_req_t;

  typedef struct packed {
    status_t     st;
    logic [15:0] pages;
    logic [7:0]  prio;
    logic [15:0] name;
    logic [4:0]  count;
  } job_reply_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  kind;
  logic [15:0] doc_id;
  logic [15:0] page_count;
  logic [7:0]  prio_level;
  logic [15:0] name_tag;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [1:0]  status;
  logic [15:0] hit_pages;
  logic [7:0]  hit_prio;
  logic [15:0] hit_name;
  logic [4:0]  entry_count;

  job_req_t   job_backlog[$];
  job_reply_t predicted_replies[$];
  job_req_t   offered_job;
  job_reply_t got_reply;
  job_reply_t want_reply;

  entry_t     job_table[TABLE_DEPTH];
  int         jobs_held;

  int         burst_left;
  int         gap_left;
  int         reqs_taken;
  int         hold_left;
  bit         hold_done;
  int         stall_mode;
  int         stall_phase_left;
  int         idle_cycles;
  int         mismatches;

  sorted_priority_table_unit #(.DEPTH(TABLE_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .doc_id      (doc_id),
    .page_count  (page_count),
    .prio_level  (prio_level),
    .name_tag    (name_tag),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .hit_pages   (hit_pages),
    .hit_prio    (hit_prio),
    .hit_name    (hit_name),
    .entry_count (entry_count)
  );

  function automatic job_req_t make_job(kind_t op, logic [15:0] id, logic [15:0] pages,
                                        logic [7:0] prio, logic [15:0] name);
    job_req_t j;
    j.op    = op;
    j.id    = id;
    j.pages = pages;
    j.prio  = prio;
    j.name  = name;
    return j;
  endfunction

  function automatic job_reply_t apply_job_to_table(job_req_t r);
    job_reply_t res;
    int         at;
    int         pos;
    int         i;
    res.st    = ST_OK;
    res.pages = '0;
    res.prio  = '0;
    res.name  = '0;
    if (r.op == KIND_INSERT) begin
      if (jobs_held >= TABLE_DEPTH) begin
        res.st = ST_FULL;
      end else begin
        at = jobs_held;
        for (i = 0; i < jobs_held; i++) begin
          if (job_table[i].prio > r.prio) begin
            at = i;
            break;
          end
        end
        for (i = jobs_held; i > at; i--) begin
          job_table[i] = job_table[i-1];
        end
        job_table[at].id    = r.id;
        job_table[at].pages = r.pages;
        job_table[at].prio  = r.prio;
        job_table[at].name  = r.name;
        jobs_held++;
      end
    end else begin
      pos = -1;
      for (i = 0; i < jobs_held; i++) begin
        if (pos < 0 && job_table[i].id == r.id) begin
          pos = i;
        end
      end
      if (pos < 0) begin
        res.st = ST_NOT_FOUND;
      end else begin
        if (r.op == KIND_UPDATE) begin
          job_table[pos].pages = r.pages;
          job_table[pos].prio  = r.prio;
          job_table[pos].name  = r.name;
        end
        res.pages = job_table[pos].pages;
        res.prio  = job_table[pos].prio;
        res.name  = job_table[pos].name;
        if (r.op == KIND_REMOVE) begin
          for (i = pos; i + 1 < jobs_held; i++) begin
            job_table[i] = job_table[i+1];
          end
          jobs_held--;
        end
      end
    end
    res.count = jobs_held[4:0];
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int       seg;
    int       n;
    int       ins_pct;
    int       pick;
    kind_t    op;
    logic [15:0] id;
    logic [7:0]  prio;
    rst = 1'b1;
    job_backlog.push_back(make_job(KIND_REMOVE, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    job_backlog.push_back(make_job(KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    job_backlog.push_back(make_job(KIND_UPDATE, 16'h0005, 16'h1234, 8'h10, 16'h5678));
    job_backlog.push_back(make_job(KIND_INSERT, 16'h0000, 16'h0000, 8'd0,   16'h0000));
    job_backlog.push_back(make_job(KIND_INSERT, 16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF));
    job_backlog.push_back(make_job(KIND_INSERT, 16'h0001, 16'h000A, 8'd100, 16'h1111));
    job_backlog.push_back(make_job(KIND_INSERT, 16'h0002, 16'h0014, 8'd100, 16'h2222));
    job_backlog.push_back(make_job(KIND_INSERT, 16'h0003, 16'h001E, 8'd50,  16'h3333));
    job_backlog.push_back(make_job(KIND_INSERT, 16'h0001, 16'h0028, 8'd20,  16'h4444));
    for (n = 4; n < 15; n++) begin
      job_backlog.push_back(make_job(KIND_INSERT, 16'(n), 16'($urandom()),
                                     8'((n * 37) % 256), 16'($urandom())));
    end
    job_backlog.push_back(make_job(KIND_LOOKUP, 16'h0001, 16'h0000, 8'h00, 16'h0000));
    job_backlog.push_back(make_job(KIND_UPDATE, 16'hFFFF, 16'hA5A5, 8'd0,  16'h5A5A));
    job_backlog.push_back(make_job(KIND_REMOVE, 16'h0001, 16'h0000, 8'h00, 16'h0000));
    job_backlog.push_back(make_job(KIND_REMOVE, 16'h0000, 16'h0000, 8'h00, 16'h0000));

    for (seg = 0; seg < 5; seg++) begin
      ins_pct = (seg % 2 == 0) ? 65 : 25;
      for (n = 0; n < 100; n++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          op = KIND_INSERT;
        end else begin
          pick = $urandom_range(0, 3);
          op = (pick < 2) ? KIND_REMOVE : (pick == 2) ? KIND_LOOKUP : KIND_UPDATE;
        end
        if ($urandom_range(0, 9) == 0) begin
          id = 16'($urandom());
        end else begin
          pick = $urandom_range(0, 11);
          id = (pick == 11) ? 16'hFFFF : 16'(pick);
        end
        prio = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
        job_backlog.push_back(make_job(op, id, 16'($urandom()), prio, 16'($urandom())));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (job_backlog.size() != 0 || req_valid) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("sorted_priority_table_unit regression: pass");
    end else begin
      $display("sorted_priority_table_unit regression: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      kind       <= '0;
      doc_id     <= '0;
      page_count <= '0;
      prio_level <= '0;
      name_tag   <= '0;
      burst_left = 0;
      gap_left   = 0;
      jobs_held  = 0;
      reqs_taken <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        predicted_replies.push_back(apply_job_to_table(offered_job));
        reqs_taken <= reqs_taken + 1;
      end
      if (!(req_valid && req_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (job_backlog.size() != 0) begin
          offered_job = job_backlog.pop_front();
          req_valid  <= 1'b1;
          kind       <= offered_job.op;
          doc_id     <= offered_job.id;
          page_count <= offered_job.pages;
          prio_level <= offered_job.prio;
          name_tag   <= offered_job.name;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // hold off once for a long stretch so the unit backs up onto its request side; otherwise stall at random in phases
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      stall_mode = 0;
      stall_phase_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (!hold_done && reqs_taken >= LONG_HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_LEN;
      rsp_stall <= 1'b1;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_phase_left = $urandom_range(5, 60);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 1) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
    end else if (rsp_valid && !rsp_stall) begin
      got_reply.st    = status_t'(status);
      got_reply.pages = hit_pages;
      got_reply.prio  = hit_prio;
      got_reply.name  = hit_name;
      got_reply.count = entry_count;
      if (predicted_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: reply word with none outstanding: st=%0d pages=%h prio=%h name=%h cnt=%0d",
                   $realtime, got_reply.st, got_reply.pages, got_reply.prio, got_reply.name,
                   got_reply.count);
        end
      end else begin
        want_reply = predicted_replies.pop_front();
        if (got_reply.st !== want_reply.st || got_reply.pages !== want_reply.pages ||
            got_reply.prio !== want_reply.prio || got_reply.name !== want_reply.name ||
            got_reply.count !== want_reply.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: reply mismatch: want st=%0d pages=%h prio=%h name=%h cnt=%0d",
                     $realtime, want_reply.st, want_reply.pages, want_reply.prio,
                     want_reply.name, want_reply.count);
            $display("%0t:                   got st=%0d pages=%h prio=%h name=%h cnt=%0d",
                     $realtime, got_reply.st, got_reply.pages, got_reply.prio,
                     got_reply.name, got_reply.count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("sorted_priority_table_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
